// ===== sv/tse_pkg.sv =====
// Shared types and byte-class constants for the text statistics engine.
package tse_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic capture;
    logic hist_upd;
    logic walk_first;
    logic walk_next;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_commit;
    logic dict_empty;
    logic match;
    logic last_slot;
    logic out_free;
  } sts_t;

  function automatic logic is_delim(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_COMMA ||
           c == CH_PERIOD || c == CH_SEMI || c == CH_COLON || c == CH_LPAR ||
           c == CH_RPAR || c == CH_SLASH || c == CH_APOS || c == CH_DQUOTE ||
           c == CH_NUL;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL;
  endfunction

endpackage

// ===== sv/tse_ctrl.sv =====
// Control sequencer: capture, histogram update, dictionary walk, result.
module tse_ctrl import tse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HIST = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_HIST;
        end
      end
      S_HIST: begin
        cmd.hist_upd = 1'b1;
        if (sts.need_commit && !sts.dict_empty) begin
          cmd.walk_first = 1'b1;
          state_next = S_WALK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_WALK: begin
        if (sts.match || sts.last_slot) begin
          state_next = S_FIN;
        end else begin
          cmd.walk_next = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ===== sv/tse_dp.sv =====
// Datapath: histogram memory, word buffer, dictionary memory, counters, result register.
module tse_dp import tse_pkg::*; #(
  parameter int MAX_WORD_CHARS = 32,
  parameter int WORD_SLOTS     = 256,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        kind,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] paragraphs,
  output logic [31:0] sentences,
  output logic [31:0] word_tally,
  output logic [8:0]  distinct_symbols,
  output logic [31:0] symbol_count,
  output logic        word_done,
  output logic [7:0]  word_index,
  output logic [31:0] word_count,
  output logic        dict_full,
  output logic        final_res
);

  localparam int CW    = COUNT_WIDTH;
  localparam int LW    = $clog2(MAX_WORD_CHARS + 1);
  localparam int IW    = $clog2(MAX_WORD_CHARS);
  localparam int SW    = $clog2(WORD_SLOTS);
  localparam int DW    = SW + 1;
  localparam int CB    = MAX_WORD_CHARS * 8;
  localparam int ROW_W = CW + LW + CB;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + CW'(1);
  endfunction

  function automatic logic [31:0] rep32(input logic [CW-1:0] v);
    logic [63:0] e;
    e = 64'(v);
    return (|e[63:32]) ? 32'hFFFF_FFFF : e[31:0];
  endfunction

  logic           kind_r;
  logic [7:0]     ch_r;
  logic [7:0]     prev_byte;
  logic           sopen;
  logic           ppend;
  logic           seen_any;
  logic [CW-1:0]  sent_tot;
  logic [CW-1:0]  para_tot;
  logic [CW-1:0]  word_tot;
  logic [8:0]     dsym;
  logic [CW-1:0]  sym_cnt;
  logic [CB-1:0]  wbuf;
  logic [LW-1:0]  wlen;
  logic [DW-1:0]  dwords;
  logic [SW-1:0]  idx;
  logic           hit;

  logic [CW-1:0]    hist_mem [256];
  logic [CW-1:0]    hist_rd;
  logic [255:0]     hist_vld;
  logic [ROW_W-1:0] dict_mem [WORD_SLOTS];
  logic [ROW_W-1:0] dict_rd;

  logic [CW-1:0] hist_cur;
  logic [CB-1:0] mask;
  logic [CW-1:0] rd_cnt;
  logic [LW-1:0] rd_len;
  logic [CB-1:0] rd_chars;
  logic          match;
  logic          full;
  logic [SW-1:0] new_slot;

  logic          sopen_next;
  logic          ppend_next;
  logic [CW-1:0] sent_next;
  logic [CW-1:0] para_next;
  logic [CW-1:0] word_next;

  assign rd_cnt   = dict_rd[ROW_W-1 -: CW];
  assign rd_len   = dict_rd[LW+CB-1 -: LW];
  assign rd_chars = dict_rd[CB-1:0];
  assign hist_cur = hist_vld[ch_r] ? hist_rd : '0;
  assign full     = (dwords >= DW'(WORD_SLOTS));
  assign new_slot = dwords[SW-1:0];

  always_comb begin
    for (int j = 0; j < MAX_WORD_CHARS; j++) begin
      mask[j*8 +: 8] = (LW'(j) < wlen) ? 8'hFF : 8'h00;
    end
  end

  assign match = (rd_len == wlen) && (((rd_chars ^ wbuf) & mask) == '0);

  always_comb begin
    sts.need_commit = (kind_r == KIND_END) ? (wlen != '0)
                    : (is_delim(ch_r) && !is_delim(prev_byte));
    sts.dict_empty  = (dwords == '0);
    sts.match       = match;
    sts.last_slot   = (DW'(idx) + DW'(1) >= dwords);
    sts.out_free    = !out_valid || !out_stall;
  end

  always_comb begin
    sopen_next = sopen;
    ppend_next = ppend;
    sent_next  = sent_tot;
    para_next  = para_tot;
    word_next  = sts.need_commit ? sat_inc(word_tot) : word_tot;
    if (kind_r == KIND_END) begin
      if (ppend && seen_any && prev_byte != CH_NL) begin
        para_next = sat_inc(para_tot);
      end
    end else begin
      if (ch_r == CH_PERIOD || ch_r == CH_BANG || ch_r == CH_QMARK) begin
        sopen_next = 1'b1;
      end else if (sopen && !is_space(ch_r)) begin
        sopen_next = 1'b0;
        sent_next  = sat_inc(sent_tot);
      end
      if (ch_r != CH_NL) begin
        ppend_next = 1'b1;
      end
      if (ch_r == CH_NL && prev_byte != CH_NL) begin
        ppend_next = 1'b0;
        para_next  = sat_inc(para_tot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hist_rd <= hist_mem[ch];
    end
    if (cmd.hist_upd && kind_r == KIND_TEXT) begin
      hist_mem[ch_r] <= sat_inc(hist_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_first) begin
      dict_rd <= dict_mem[0];
    end else if (cmd.walk_next) begin
      dict_rd <= dict_mem[idx + SW'(1)];
    end
    if (cmd.finish && sts.need_commit) begin
      if (hit) begin
        dict_mem[idx] <= {sat_inc(rd_cnt), wlen, wbuf};
      end else if (!full) begin
        dict_mem[new_slot] <= {CW'(1), wlen, wbuf};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind;
      ch_r   <= ch;
    end
    if (cmd.walk_first) begin
      idx <= '0;
    end else if (cmd.walk_next) begin
      idx <= idx + SW'(1);
    end
    if (cmd.hist_upd) begin
      sym_cnt <= (kind_r == KIND_TEXT) ? sat_inc(hist_cur) : '0;
    end
    if (cmd.finish && kind_r == KIND_TEXT && !is_delim(ch_r) &&
        wlen < LW'(MAX_WORD_CHARS)) begin
      wbuf[wlen[IW-1:0]*8 +: 8] <= ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.capture) begin
      hit <= 1'b0;
    end else if (cmd.walk_first || cmd.walk_next) begin
      hit <= 1'b0;
    end else if (match && !hit && dwords != '0 && !cmd.finish && !cmd.hist_upd) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte <= '0;
      sopen     <= 1'b1;
      ppend     <= 1'b1;
      seen_any  <= 1'b0;
      sent_tot  <= '0;
      para_tot  <= '0;
      word_tot  <= '0;
      dsym      <= '0;
      hist_vld  <= '0;
      wlen      <= '0;
      dwords    <= '0;
    end else begin
      if (cmd.hist_upd && kind_r == KIND_TEXT) begin
        hist_vld[ch_r] <= 1'b1;
        if (!hist_vld[ch_r]) begin
          dsym <= dsym + 9'd1;
        end
      end
      if (cmd.finish) begin
        if (kind_r == KIND_END) begin
          prev_byte <= '0;
          sopen     <= 1'b1;
          ppend     <= 1'b1;
          seen_any  <= 1'b0;
          sent_tot  <= '0;
          para_tot  <= '0;
          word_tot  <= '0;
          dsym      <= '0;
          hist_vld  <= '0;
          wlen      <= '0;
          dwords    <= '0;
        end else begin
          prev_byte <= ch_r;
          sopen     <= sopen_next;
          ppend     <= ppend_next;
          seen_any  <= 1'b1;
          sent_tot  <= sent_next;
          para_tot  <= para_next;
          word_tot  <= word_next;
          if (is_delim(ch_r)) begin
            if (sts.need_commit) begin
              wlen <= '0;
            end
          end else if (wlen < LW'(MAX_WORD_CHARS)) begin
            wlen <= wlen + LW'(1);
          end
          if (sts.need_commit && !hit && !full) begin
            dwords <= dwords + DW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      paragraphs       <= rep32(para_next);
      sentences        <= rep32(sent_next);
      word_tally       <= rep32(word_next);
      distinct_symbols <= dsym;
      symbol_count     <= (kind_r == KIND_END) ? 32'd0 : rep32(sym_cnt);
      word_done        <= sts.need_commit;
      final_res        <= (kind_r == KIND_END);
      dict_full        <= sts.need_commit && !hit && full;
      if (sts.need_commit && hit) begin
        word_index <= 8'(32'(idx));
        word_count <= rep32(sat_inc(rd_cnt));
      end else if (sts.need_commit && !full) begin
        word_index <= 8'(32'(new_slot));
        word_count <= 32'd1;
      end else begin
        word_index <= 8'd0;
        word_count <= 32'd0;
      end
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && kind_r == KIND_END |=> dwords == '0 && wlen == '0 && dsym == '0)
    else $error("end of text did not clear state");
  a_dsym_range: assert property (@(posedge clk) disable iff (rst)
    dsym <= 9'd256)
    else $error("distinct symbol count out of range");
  a_wlen_range: assert property (@(posedge clk) disable iff (rst)
    wlen <= LW'(MAX_WORD_CHARS))
    else $error("word length beyond buffer");
  a_dwords_range: assert property (@(posedge clk) disable iff (rst)
    dwords <= DW'(WORD_SLOTS))
    else $error("dictionary fill beyond slots");

endmodule

// ===== sv/text_statistics_engine_top.sv =====
// Top level of the text statistics engine: sequencer plus datapath.
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | kind, ch
//   out     | output    | out_valid/out_stall | paragraphs .. final_res
// A byte passes through capture, histogram read-modify-write and result.
// A word end adds a walk over the dictionary slots (one row read per cycle).
// Reset is synchronous; the histogram clears at once through per-bin valid bits.
// A waiting result does not block the next transfer on the input side.
module text_statistics_engine_top import tse_pkg::*; #(
  parameter int MAX_WORD_CHARS = 32,
  parameter int WORD_SLOTS     = 256,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] paragraphs,
  output logic [31:0] sentences,
  output logic [31:0] word_tally,
  output logic [8:0]  distinct_symbols,
  output logic [31:0] symbol_count,
  output logic        word_done,
  output logic [7:0]  word_index,
  output logic [31:0] word_count,
  output logic        dict_full,
  output logic        final_res
);

  cmd_t cmd;
  sts_t sts;

  tse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tse_dp #(
    .MAX_WORD_CHARS (MAX_WORD_CHARS),
    .WORD_SLOTS     (WORD_SLOTS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .kind             (kind),
    .ch               (ch),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .paragraphs       (paragraphs),
    .sentences        (sentences),
    .word_tally       (word_tally),
    .distinct_symbols (distinct_symbols),
    .symbol_count     (symbol_count),
    .word_done        (word_done),
    .word_index       (word_index),
    .word_count       (word_count),
    .dict_full        (dict_full),
    .final_res        (final_res)
  );

endmodule
